@@ rtl/gtm_pkg.sv @@
// shared constants, command codes and controller command bundle for the gemm tile
`timescale 1ns / 1ps

package gtm_pkg;

  // tile geometry
  localparam int TILE_ROWS = 8;
  localparam int TILE_COLS = 24;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 5;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int ACC_DEPTH = TILE_ROWS * TILE_COLS;
  localparam int ACC_AW    = $clog2(ACC_DEPTH);
  localparam int ADDR_W    = 3;

  // input command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_MAC    = 2'd2;
  localparam logic [1:0] CMD_FINAL  = 2'd3;

  // register select, taken from paddr bit 2
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  // gain reset values (q16.16)
  localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;
  localparam logic signed [DATA_W-1:0] BETA_RESET  = 32'sd0;

  // per-cycle strobes from controller to datapath
  typedef struct packed {
    logic             cap;
    logic             clr;
    logic             b_wr;
    logic             rd;
    logic [COL_W-1:0] rd_col;
    logic             fin_rd;
    logic             mac_mul;
    logic             mac_wr;
    logic             fin_sat;
    logic             fin_mul_a;
    logic             fin_mul_b;
    logic             fin_sum;
    logic             fin_out;
  } gtm_cmd_t;

endpackage

@@ rtl/gemm_tile_8x24_mac.sv @@
// gemm tile top: 8x24 q32.32 accumulator tile with one shared multiply-accumulate
// clear and b load: one beat per cycle while idle
// accumulate: in_stall held; one accumulator per cycle over 24 columns plus 2 pipe stages
// finalize: read, saturate, alpha mul, beta mul, sum, output; output held off by out_stall
// reset: rst_n synchronous active low; tile reads zero via per-entry valid flags, no sweep
// b row undefined until loaded; alpha resets to 1.0, beta to 0; one shared multiplier
`timescale 1ns / 1ps

module gemm_tile_8x24_mac import gtm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [COL_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_operand,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  output logic signed [DATA_W-1:0] out_c_result,
  output logic                     out_saturated,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  gtm_cmd_t                 cmd;
  logic                     cfg_we;
  logic signed [DATA_W-1:0] alpha_gain;
  logic signed [DATA_W-1:0] beta_gain;

  // register port decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BETA) ? beta_gain : alpha_gain;

  // sequencer
  gtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_row    (in_row),
    .in_col    (in_col),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  gtm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_operand    (in_operand),
    .cfg_we        (cfg_we),
    .cfg_sel       (paddr[2]),
    .cfg_wdata     (pwdata),
    .alpha_gain    (alpha_gain),
    .beta_gain     (beta_gain),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_c_result  (out_c_result),
    .out_saturated (out_saturated)
  );

endmodule

@@ rtl/gtm_ctrl.sv @@
// sequencer for the gemm tile: accepts beats, steps columns, drives datapath strobes
`timescale 1ns / 1ps

module gtm_ctrl import gtm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [ROW_W-1:0] in_row,
  input  logic [COL_W-1:0] in_col,
  output logic             out_valid,
  input  logic             out_stall,
  output gtm_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FRD,
    ST_FSAT,
    ST_FMA,
    ST_FMB,
    ST_FSUM,
    ST_FOUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic             mul_r, mul_nxt;
  logic             wr_r, wr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             row_ok;
  logic             col_ok;
  logic             fin_go;

  // handshake and range checks
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign row_ok    = int'(in_row) < TILE_ROWS;
  assign col_ok    = int'(in_col) < TILE_COLS;
  assign fin_go    = (state_r == ST_FOUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt   = state_r;
    col_cnt_nxt = col_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd) inside
            CMD_MAC: begin
              if (row_ok) begin
                state_nxt   = ST_MAC;
                col_cnt_nxt = '0;
              end
            end
            CMD_FINAL: begin
              if (row_ok && col_ok) state_nxt = ST_FRD;
            end
            CMD_CLEAR, CMD_LOAD_B: ;
          endcase
        end
      end
      ST_MAC: begin
        col_cnt_nxt = col_cnt_r + 1'b1;
        if (col_cnt_r == COL_W'(TILE_COLS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_FRD:   state_nxt = ST_FSAT;
      ST_FSAT:  state_nxt = ST_FMA;
      ST_FMA:   state_nxt = ST_FMB;
      ST_FMB:   state_nxt = ST_FSUM;
      ST_FSUM:  state_nxt = ST_FOUT;
      ST_FOUT: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // pipeline strobe delays and output slot
  assign mul_nxt       = (state_r == ST_MAC);
  assign wr_nxt        = mul_r;
  assign out_valid_nxt = fin_go || (out_valid_r && out_stall);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_cnt_r   <= '0;
      mul_r       <= 1'b0;
      wr_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_cnt_r   <= col_cnt_nxt;
      mul_r       <= mul_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath strobes
  always_comb begin
    cmd           = '0;
    cmd.cap       = accept;
    cmd.clr       = accept && (in_cmd == CMD_CLEAR);
    cmd.b_wr      = accept && (in_cmd == CMD_LOAD_B) && col_ok;
    cmd.rd        = (state_r == ST_MAC);
    cmd.rd_col    = col_cnt_r;
    cmd.fin_rd    = (state_r == ST_FRD);
    cmd.mac_mul   = mul_r;
    cmd.mac_wr    = wr_r;
    cmd.fin_sat   = (state_r == ST_FSAT);
    cmd.fin_mul_a = (state_r == ST_FMA);
    cmd.fin_mul_b = (state_r == ST_FMB);
    cmd.fin_sum   = (state_r == ST_FSUM);
    cmd.fin_out   = fin_go;
  end

`ifndef SYNTHESIS
  // column counter stays inside the tile while stepping
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (int'(col_cnt_r) < TILE_COLS))
    else $error("column counter left the tile");

  // writeback always comes in the cycle after a multiply
  a_wr_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_wr |-> $past(cmd.mac_mul))
    else $error("accumulator writeback without multiply");

  // no multiply still in flight once a new beat can be taken
  a_idle_no_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cmd.mac_mul)
    else $error("multiply in flight while idle");

  // a result appears only after the output step of a finalize
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FOUT))
    else $error("result raised outside finalize");
`endif

endmodule

@@ rtl/gtm_dp.sv @@
// gemm tile datapath: b row, accumulator memory, shared multiplier and saturating adder
`timescale 1ns / 1ps

module gtm_dp import gtm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gtm_cmd_t                 cmd,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [COL_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_operand,
  input  logic                     cfg_we,
  input  logic                     cfg_sel,
  input  logic [DATA_W-1:0]        cfg_wdata,
  output logic signed [DATA_W-1:0] alpha_gain,
  output logic signed [DATA_W-1:0] beta_gain,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  output logic signed [DATA_W-1:0] out_c_result,
  output logic                     out_saturated
);

  // saturating signed 64-bit add, overflow flag on top
  function automatic logic [ACC_W:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                               input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    logic [ACC_W:0]          r;
    s = a + b;
    r = {1'b0, s};
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      r = a[ACC_W-1] ? {1'b1, 1'b1, {(ACC_W-1){1'b0}}}
                     : {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  // floor shift right by 16, then saturate to 32 bits, flag on top
  function automatic logic [DATA_W:0] shr16_sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-17:0] sh;
    logic [DATA_W:0]   r;
    sh = v[ACC_W-1:16];
    r  = {1'b0, sh[DATA_W-1:0]};
    if (!((&sh[ACC_W-17:DATA_W-1]) || !(|sh[ACC_W-17:DATA_W-1]))) begin
      r = sh[ACC_W-17] ? {1'b1, 1'b1, {(DATA_W-1){1'b0}}}
                       : {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // captured beat and gains
  logic [ROW_W-1:0]         row_r;
  logic [COL_W-1:0]         col_r;
  logic signed [DATA_W-1:0] opnd_r;
  logic signed [DATA_W-1:0] alpha_r;
  logic signed [DATA_W-1:0] beta_r;

  // storage
  logic signed [DATA_W-1:0] b_mem [TILE_COLS];
  logic signed [ACC_W-1:0]  acc_mem [ACC_DEPTH];
  logic [ACC_DEPTH-1:0]     vld_r;
  logic [ACC_DEPTH-1:0]     stk_r;

  // read stage
  logic signed [DATA_W-1:0] b_rd_r;
  logic signed [ACC_W-1:0]  acc_rd_r;
  logic                     vld_rd_r;
  logic                     stk_rd_r;
  logic [ACC_AW-1:0]        addr1_r;
  logic [ACC_AW-1:0]        addr2_r;

  // arithmetic stages
  logic signed [ACC_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  accv_r;
  logic signed [ACC_W-1:0]  hold_r;
  logic signed [DATA_W-1:0] acc16_r;
  logic signed [ACC_W-1:0]  sum_r;
  logic                     sat_r;

  // result register
  logic [ROW_W-1:0]         out_row_r;
  logic [COL_W-1:0]         out_col_r;
  logic signed [DATA_W-1:0] out_c_result_r;
  logic                     out_sat_r;

  logic [COL_W-1:0]         rd_col_sel;
  logic [ACC_AW-1:0]        rd_addr;
  logic                     rd_any;
  logic signed [ACC_W-1:0]  acc_masked;
  logic signed [DATA_W-1:0] mul_x;
  logic signed [DATA_W-1:0] mul_y;
  logic signed [ACC_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]  add_a;
  logic [ACC_W:0]           add_res;
  logic signed [ACC_W-1:0]  sh_in;
  logic [DATA_W:0]          sh_res;

  // read address: stepped column for accumulate, captured column for finalize
  assign rd_col_sel = cmd.fin_rd ? col_r : cmd.rd_col;
  assign rd_addr    = ACC_AW'(row_r) * ACC_AW'(TILE_COLS) + ACC_AW'(rd_col_sel);
  assign rd_any     = cmd.rd || cmd.fin_rd;
  assign acc_masked = vld_rd_r ? acc_rd_r : '0;

  // shared multiplier operand select
  always_comb begin
    if (cmd.mac_mul) begin
      mul_x = opnd_r;
      mul_y = b_rd_r;
    end else if (cmd.fin_mul_a) begin
      mul_x = alpha_r;
      mul_y = acc16_r;
    end else begin
      mul_x = beta_r;
      mul_y = opnd_r;
    end
  end
  assign mul_p = mul_x * mul_y;

  // shared saturating adder and shift/saturate unit
  assign add_a   = cmd.fin_sum ? hold_r : accv_r;
  assign add_res = sat_add64(add_a, prod_r);
  assign sh_in   = cmd.fin_out ? sum_r : acc_masked;
  assign sh_res  = shr16_sat32(sh_in);

  // gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      beta_r  <= BETA_RESET;
    end else if (cfg_we) begin
      if (cfg_sel == REG_BETA) beta_r <= cfg_wdata;
      else alpha_r <= cfg_wdata;
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      row_r  <= in_row;
      col_r  <= in_col;
      opnd_r <= in_operand;
    end
  end

  // b row write and read
  always_ff @(posedge clk) begin
    if (cmd.b_wr) b_mem[in_col] <= in_operand;
    if (cmd.rd) b_rd_r <= b_mem[cmd.rd_col];
  end

  // accumulator memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.mac_wr) acc_mem[addr2_r] <= add_res[ACC_W-1:0];
    if (rd_any) begin
      acc_rd_r <= acc_mem[rd_addr];
      vld_rd_r <= vld_r[rd_addr];
      stk_rd_r <= stk_r[rd_addr];
      addr1_r  <= rd_addr;
    end
    if (cmd.mac_mul) addr2_r <= addr1_r;
  end

  // per-entry valid and sticky flags, clear wins over a same-cycle writeback
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      stk_r <= '0;
    end else begin
      if (cmd.mac_wr) begin
        vld_r[addr2_r] <= 1'b1;
        if (add_res[ACC_W]) stk_r[addr2_r] <= 1'b1;
      end
      if (cmd.clr) begin
        vld_r <= '0;
        stk_r <= '0;
      end
    end
  end

  // multiply and finalize stages
  always_ff @(posedge clk) begin
    if (cmd.mac_mul || cmd.fin_mul_a || cmd.fin_mul_b) prod_r <= mul_p;
    if (cmd.mac_mul) accv_r <= acc_masked;
    if (cmd.fin_mul_b) hold_r <= prod_r;
    if (cmd.fin_sat) begin
      acc16_r <= sh_res[DATA_W-1:0];
      sat_r   <= stk_rd_r || sh_res[DATA_W];
    end
    if (cmd.fin_sum) begin
      sum_r <= add_res[ACC_W-1:0];
      sat_r <= sat_r || add_res[ACC_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin_out) begin
      out_row_r      <= row_r;
      out_col_r      <= col_r;
      out_c_result_r <= sh_res[DATA_W-1:0];
      out_sat_r      <= sat_r || sh_res[DATA_W];
    end
  end

  assign alpha_gain    = alpha_r;
  assign beta_gain     = beta_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_c_result  = out_c_result_r;
  assign out_saturated = out_sat_r;

endmodule

@@ sim/gtm_checker.sv @@
// scoreboard for the gemm tile: watches both channels and the register port, predicts and compares
`timescale 1ns / 1ps

module gtm_checker import gtm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [COL_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_operand,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [ROW_W-1:0]         out_row,
  input  logic [COL_W-1:0]         out_col,
  input  logic signed [DATA_W-1:0] out_c_result,
  input  logic                     out_saturated,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  input  logic                     pready,
  output int unsigned              pending,
  output int unsigned              errors
);

  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = -S64_MAX - 1;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int     PRINT_CAP = 40;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] c_val;
    logic              sat;
  } c_elem_t;

  // model state: gains, b row, q32.32 tile and sticky saturation flags
  longint  alpha_gain;
  longint  beta_gain;
  longint  b_row [TILE_COLS];
  longint  acc_tile [ACC_DEPTH];
  bit      acc_sat [ACC_DEPTH];
  c_elem_t c_elem_q [$];
  int unsigned miss_n;

  // 64-bit add clamped to the signed range
  function automatic longint sat_add(input longint a, input longint b, inout bit s);
    logic signed [64:0] wide;
    wide = a;
    wide = wide + b;
    if (wide > S64_MAX) begin
      s = 1'b1;
      return S64_MAX;
    end
    if (wide < S64_MIN) begin
      s = 1'b1;
      return S64_MIN;
    end
    return wide[63:0];
  endfunction

  function automatic longint clamp32(input longint v, inout bit s);
    if (v > S32_MAX) begin
      s = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      s = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  task automatic report_miss(input string msg);
    miss_n++;
    if (miss_n <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
  endtask

  // apply one accepted input beat to the model
  task automatic take_beat(input logic [1:0] cmd, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input longint opnd);
    int      k;
    bit      s;
    longint  acc16;
    longint  sum;
    longint  r;
    c_elem_t elem;
    case (cmd)
      CMD_CLEAR: begin
        foreach (acc_tile[i]) begin
          acc_tile[i] = 0;
          acc_sat[i]  = 1'b0;
        end
      end
      CMD_LOAD_B: begin
        if (col < TILE_COLS) b_row[col] = opnd;
      end
      CMD_MAC: begin
        if (row < TILE_ROWS) begin
          for (int j = 0; j < TILE_COLS; j++) begin
            k = row * TILE_COLS + j;
            s = 1'b0;
            acc_tile[k] = sat_add(acc_tile[k], opnd * b_row[j], s);
            if (s) acc_sat[k] = 1'b1;
          end
        end
      end
      default: begin
        // finalize: q32.32 -> q16.16, scale, add scaled old c, back to q16.16
        if (row < TILE_ROWS && col < TILE_COLS) begin
          k = row * TILE_COLS + col;
          s = acc_sat[k];
          acc16 = clamp32(acc_tile[k] >>> 16, s);
          sum = sat_add(alpha_gain * acc16, beta_gain * opnd, s);
          r = clamp32(sum >>> 16, s);
          elem.row   = row;
          elem.col   = col;
          elem.c_val = r[31:0];
          elem.sat   = s;
          c_elem_q.push_back(elem);
        end
      end
    endcase
  endtask

  // compare one result beat with the oldest pending element
  task automatic check_result();
    c_elem_t want;
    if (c_elem_q.size() == 0) begin
      report_miss($sformatf("result beat with nothing pending: row %0d col %0d c %h",
                            out_row, out_col, out_c_result));
    end else begin
      want = c_elem_q.pop_front();
      if (out_row !== want.row || out_col !== want.col ||
          out_c_result !== want.c_val || out_saturated !== want.sat)
        report_miss($sformatf("got row %0d col %0d c %h sat %b, want row %0d col %0d c %h sat %b",
                              out_row, out_col, out_c_result, out_saturated,
                              want.row, want.col, want.c_val, want.sat));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      alpha_gain = longint'(ALPHA_RESET);
      beta_gain  = longint'(BETA_RESET);
      foreach (b_row[i]) b_row[i] = 0;
      foreach (acc_tile[i]) begin
        acc_tile[i] = 0;
        acc_sat[i]  = 1'b0;
      end
      c_elem_q.delete();
      miss_n = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ALPHA) alpha_gain = longint'($signed(pwdata));
        else beta_gain = longint'($signed(pwdata));
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_beat(in_cmd, in_row, in_col, longint'(in_operand));
    end
    pending <= c_elem_q.size();
    errors  <= miss_n;
  end

endmodule

@@ sim/tb_top.sv @@
// testbench top for the gemm tile: clock, reset, stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module tb_top;
  import gtm_pkg::*;

  localparam int          RAND_PER_PHASE = 250;
  localparam int          N_PHASES       = 6;
  localparam int          DRAIN_CYCLES   = 128;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [ADDR_W-1:0] ADDR_ALPHA = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_BETA  = 3'd4;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_cmd     = CMD_CLEAR;
  logic [ROW_W-1:0]         in_row     = '0;
  logic [COL_W-1:0]         in_col     = '0;
  logic signed [DATA_W-1:0] in_operand = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_c_result;
  logic                     out_saturated;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [ADDR_W-1:0]        paddr   = '0;
  logic [DATA_W-1:0]        pwdata  = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  int unsigned pending_n;
  int unsigned err_n;
  int unsigned beats_in  = 0;
  int unsigned beats_out = 0;
  int unsigned idle_cycles = 0;
  logic [TILE_COLS-1:0] b_loaded = '0;
  bit no_idle   = 1'b0;
  bit press_req = 1'b0;
  bit press_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gemm_tile_8x24_mac DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_row, .in_col, .in_operand,
    .out_valid, .out_stall, .out_row, .out_col, .out_c_result, .out_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gtm_checker chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_row, .in_col, .in_operand,
    .out_valid, .out_stall, .out_row, .out_col, .out_c_result, .out_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending(pending_n), .errors(err_n)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small q16.16 values, corner values or anything
  function automatic logic [DATA_W-1:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    if (r < 55) begin
      case ($urandom_range(0, 5))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        4: return 32'h0000_0001;
        default: return 32'h0001_0000;
      endcase
    end
    return $urandom;
  endfunction

  // one input beat: optional gap, then hold until accepted
  task automatic send_item(input logic [1:0] cmd, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [DATA_W-1:0] opnd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_row     <= row;
    in_col     <= col;
    in_operand <= opnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_LOAD_B && col < TILE_COLS) b_loaded[col] = 1'b1;
    beats_in++;
  endtask

  task automatic rand_item();
    int unsigned      pick;
    logic [1:0]       cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pick = $urandom_range(0, 99);
    if (pick < 3) cmd = CMD_CLEAR;
    else if (pick < 28) cmd = CMD_LOAD_B;
    else if (pick < 63) cmd = CMD_MAC;
    else cmd = CMD_FINAL;
    row = ROW_W'($urandom);
    col = COL_W'(($urandom_range(0, 99) < 8) ? $urandom_range(24, 31)
                                              : $urandom_range(0, 23));
    // accumulate reads the whole b row, so fill any hole first
    if (cmd == CMD_MAC && b_loaded != '1) begin
      cmd = CMD_LOAD_B;
      for (int j = TILE_COLS - 1; j >= 0; j--)
        if (!b_loaded[j]) col = COL_W'(j);
    end
    send_item(cmd, row, col, pick_operand());
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every finalize has answered, then let any accumulate finish
  task automatic settle();
    @(posedge clk);
    while (pending_n != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side stall pattern, with one long hold-off while input keeps coming
  initial begin
    int unsigned stall_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (press_req && !press_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        press_done = 1'b1;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : 24) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no beat and no register access
  always @(posedge clk) begin
    if (out_valid && !out_stall) beats_out <= beats_out + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_n);
      $display("gemm_tile_8x24_mac: mismatch");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] alpha_set [N_PHASES];
    logic [DATA_W-1:0] beta_set  [N_PHASES];
    alpha_set = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000};
    beta_set  = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000};
    alpha_set[4] = $urandom;
    beta_set[4]  = $urandom;
    alpha_set[5] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    beta_set[5]  = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on reset gains: empty tile, ignored positions, corner products
    send_item(CMD_FINAL, 3'd7, 5'd23, 32'h8000_0000);
    send_item(CMD_FINAL, 3'd0, 5'd31, 32'h7FFF_FFFF);
    send_item(CMD_LOAD_B, 3'd7, 5'd24, 32'h1234_5678);
    for (int j = 0; j < TILE_COLS; j++) begin
      case (j)
        0:       send_item(CMD_LOAD_B, 3'd0, COL_W'(j), 32'h7FFF_FFFF);
        1:       send_item(CMD_LOAD_B, 3'd0, COL_W'(j), 32'h8000_0000);
        TILE_COLS - 1: send_item(CMD_LOAD_B, 3'd7, COL_W'(j), 32'hFFFF_FFFF);
        default: send_item(CMD_LOAD_B, 3'd0, COL_W'(j), 32'h0001_0000 * j);
      endcase
    end
    send_item(CMD_MAC, 3'd0, 5'd0, 32'h7FFF_FFFF);
    send_item(CMD_MAC, 3'd0, 5'd31, 32'h7FFF_FFFF);
    send_item(CMD_MAC, 3'd7, 5'd0, 32'h8000_0000);
    send_item(CMD_FINAL, 3'd0, 5'd0, 32'h0000_0000);
    send_item(CMD_FINAL, 3'd0, 5'd1, 32'hFFFF_FFFF);
    send_item(CMD_FINAL, 3'd7, 5'd23, 32'h7FFF_FFFF);
    send_item(CMD_CLEAR, 3'd5, 5'd17, 32'hA5A5_A5A5);
    send_item(CMD_FINAL, 3'd0, 5'd0, 32'h0001_0000);

    // random phases, each under its own gain setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      in_valid <= 1'b0;
      settle();
      cfg_write(ADDR_ALPHA, alpha_set[ph]);
      cfg_write(ADDR_BETA, beta_set[ph]);
      no_idle = (ph == 4);
      if (ph == 2) press_req = 1'b1;
      repeat (RAND_PER_PHASE) rand_item();
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    settle();

    $display("run covered %0d input beats and %0d result beats over %0d gain settings",
             beats_in, beats_out, N_PHASES + 1);
    $display("including corner gains, ignored positions, clears and one long result hold-off");
    if (err_n == 0)
      $display("gemm_tile_8x24_mac: match");
    else
      $display("gemm_tile_8x24_mac: mismatch");
    $finish;
  end

endmodule

@@ gemm_tile_8x24_mac.f @@
rtl/gtm_pkg.sv
rtl/gtm_ctrl.sv
rtl/gtm_dp.sv
rtl/gemm_tile_8x24_mac.sv
sim/gtm_checker.sv
sim/tb_top.sv
